// File: sv/assert_macros.svh
// assertion helpers used by sparse_xor_overlay_store.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SXOS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define SXOS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/sxos_pkg.sv
`timescale 1ns / 1ps
package sxos_pkg;

	localparam int LIST_DEPTH_DEF = 512;
	localparam int LINES_DEF = 8;
	localparam int WORDS_PER_LINE_DEF = 16;

	localparam int MAP_WORD_BITS = 16;
	localparam int X_TO_WORD_SHIFT = 4;
	localparam int BIT_W = $clog2(MAP_WORD_BITS);

	// width of the list_limit register and of the entry count field
	localparam int CFG_W = 10;
	localparam logic [CFG_W-1:0] LIST_LIMIT_RST = 10'd512;

	typedef enum logic [1:0] {
		CMD_MODIFY = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_SCAN_END,
		S_DECIDE,
		S_LREAD,
		S_COPY,
		S_DRAIN,
		S_PUT,
		S_FIN
	} state_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] world_x;
		logic [2:0] line;
		logic [7:0] pixels;
		logic       keep_added;
	} in_t;

	typedef struct packed {
		logic [7:0]       pixels_out;
		logic             status;
		logic [CFG_W-1:0] entry_count;
	} out_t;

	function automatic logic [4:0] ones16(input logic [15:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 16; i++) begin
			n = n + 5'(v[i]);
		end
		return n;
	endfunction

endpackage

// File: sv/sxos_ram.sv
`timescale 1ns / 1ps
module sxos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/sparse_xor_overlay_store.sv
`timescale 1ns / 1ps
// channel   direction  handshake               payload
// in        to block   in_valid / in_stall     in_data  (in_t)
// out       from block out_valid / out_stall   out_data (out_t)
// cfg       to block   psel penable pwrite     paddr pwdata prdata, pready tied high
//
// each beat scans the bitmap from word 0 up to its own word (word = line*16 + column), one bitmap
// word read per cycle from the bitmap ram, reads its list entry when the item is present, and on
// insert or delete shifts the list entries behind it, one byte per cycle through the list ram;
// the next beat is taken only once the last one has handed its result to the out register
// clear, out-of-grid items and unused codes skip the scan and go straight to the result
// reset zeroes the count and the bitmap valid bits and sets the limit; the list ram is not cleared
// a new item is taken while a result waits on a stalled out channel
`include "assert_macros.svh"
module sparse_xor_overlay_store import sxos_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF,
	parameter int LINES = LINES_DEF,
	parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int MAP_WORDS = LINES * WORDS_PER_LINE;
	localparam int MW_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int LA_W = $clog2(LIST_DEPTH);
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	state_t state_q, state_d;

	in_t              item_q;
	logic             in_grid_q;
	logic [MW_W-1:0]  word_q;
	logic [MW_W-1:0]  scan_q;
	logic [CNT_W-1:0] rank_q;
	logic [15:0]      wrd_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] cp_q;
	logic             del_q;
	logic [7:0]       res_px_q;
	logic             status_q;
	logic [CFG_W-1:0] list_limit_q;
	logic [MAP_WORDS-1:0] bm_vld_q;
	logic             out_valid_q;
	out_t             out_data_q;

	logic             bm_rd_s1, bm_last_s1, bm_ok_s1;
	logic             cp_vld_s1;
	logic [LA_W-1:0]  cp_dst_s1;

	// memory ports
	logic             bm_we, bm_re;
	logic [MW_W-1:0]  bm_raddr;
	logic [15:0]      bm_wdata, bm_rdata;
	logic             lst_we, lst_re;
	logic [LA_W-1:0]  lst_waddr, lst_raddr;
	logic [7:0]       lst_wdata, lst_rdata;

	// decisions
	logic             in_acc;
	logic [4:0]       col;
	logic             in_grid;
	logic [BIT_W-1:0] bit_idx;
	logic [15:0]      bit_m;
	logic [15:0]      low_m;
	logic [CNT_W-1:0] rank_full;
	logic             present;
	logic [CMP_W-1:0] lim_wide;
	logic [CNT_W-1:0] lim;
	logic [7:0]       e_new;
	logic [CNT_W-1:0] cp_m1;
	logic [CMP_W-1:0] cnt_wide;
	logic             is_rd, is_mod;
	logic             out_load;
	logic             cp_issue;
	logic             cfg_wr;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(list_limit_q);
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

	assign col = 5'(in_data.world_x >> X_TO_WORD_SHIFT);
	assign in_grid = (int'(in_data.line) < LINES) && (int'(col) < WORDS_PER_LINE);

	assign bit_idx = item_q.world_x[BIT_W-1:0];
	assign bit_m = 16'(1) << bit_idx;
	assign low_m = bit_m - 16'(1);
	assign rank_full = rank_q + CNT_W'(ones16(wrd_q & low_m));
	assign present = |(wrd_q & bit_m);
	assign lim_wide = (CMP_W'(list_limit_q) < CMP_W'(LIST_DEPTH)) ?
		CMP_W'(list_limit_q) : CMP_W'(LIST_DEPTH);
	assign lim = lim_wide[CNT_W-1:0];
	assign e_new = lst_rdata ^ item_q.pixels;
	assign cp_m1 = cp_q - CNT_W'(1);
	assign cnt_wide = CMP_W'(total_q);
	assign is_rd = (item_q.cmd == CMD_READ);
	assign is_mod = (item_q.cmd == CMD_MODIFY);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign cp_issue = (state_q == S_COPY) && (del_q ? (cp_q < total_q) : (cp_q > rank_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		bm_re = 1'b0;
		bm_raddr = scan_q;
		bm_we = 1'b0;
		bm_wdata = wrd_q;
		lst_re = 1'b0;
		lst_raddr = rank_full[LA_W-1:0];
		lst_we = 1'b0;
		lst_waddr = rank_q[LA_W-1:0];
		lst_wdata = item_q.pixels;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if ((is_rd || is_mod) && in_grid_q) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SCAN: begin
				bm_re = 1'b1;
				if (scan_q == word_q) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_FIN;
				if (is_rd) begin
					if (present && rank_full < lim) begin
						lst_re = 1'b1;
						state_d = S_LREAD;
					end
				end else if (rank_full < lim) begin
					if (present) begin
						lst_re = 1'b1;
						state_d = S_LREAD;
					end else if (item_q.pixels != 8'd0 && total_q < lim) begin
						bm_we = 1'b1;
						bm_wdata = wrd_q | bit_m;
						state_d = S_COPY;
					end
				end
			end
			S_LREAD: begin
				state_d = S_FIN;
				if (is_mod) begin
					lst_we = 1'b1;
					lst_wdata = e_new;
					if (e_new == 8'd0) begin
						bm_we = 1'b1;
						bm_wdata = wrd_q & ~bit_m;
						state_d = S_COPY;
					end
				end
			end
			S_COPY: begin
				lst_raddr = del_q ? cp_q[LA_W-1:0] : cp_m1[LA_W-1:0];
				lst_re = cp_issue;
				if (!cp_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = del_q ? S_FIN : S_PUT;
			end
			S_PUT: begin
				lst_we = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// pending copy beat lands in the cycle after its read
		if (cp_vld_s1) begin
			lst_we = 1'b1;
			lst_waddr = cp_dst_s1;
			lst_wdata = lst_rdata;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			list_limit_q <= LIST_LIMIT_RST;
			bm_vld_q <= '0;
			out_valid_q <= 1'b0;
			bm_rd_s1 <= 1'b0;
			cp_vld_s1 <= 1'b0;
		end else begin
			bm_rd_s1 <= bm_re;
			cp_vld_s1 <= cp_issue;
			if (cfg_wr) begin
				list_limit_q <= pwdata[CFG_W-1:0];
			end
			if (bm_we) begin
				bm_vld_q[word_q] <= 1'b1;
			end
			if (state_q == S_START && item_q.cmd == CMD_CLEAR) begin
				bm_vld_q <= '0;
				total_q <= '0;
			end
			if (state_q == S_DRAIN && del_q) begin
				total_q <= total_q - CNT_W'(1);
			end
			if (state_q == S_PUT) begin
				total_q <= total_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
			in_grid_q <= in_grid;
			word_q <= in_grid ?
				MW_W'(int'(in_data.line) * WORDS_PER_LINE + int'(col)) : '0;
			res_px_q <= '0;
			status_q <= 1'b0;
		end
		bm_last_s1 <= (scan_q == word_q);
		bm_ok_s1 <= bm_vld_q[scan_q];
		cp_dst_s1 <= del_q ? cp_m1[LA_W-1:0] : cp_q[LA_W-1:0];
		if (bm_rd_s1) begin
			if (bm_last_s1) begin
				wrd_q <= bm_ok_s1 ? bm_rdata : 16'd0;
			end else if (bm_ok_s1) begin
				rank_q <= rank_q + CNT_W'(ones16(bm_rdata));
			end
		end
		if (bm_re) begin
			scan_q <= scan_q + MW_W'(1);
		end
		if (cp_issue) begin
			cp_q <= del_q ? (cp_q + CNT_W'(1)) : cp_m1;
		end
		case (state_q)
			S_START: begin
				scan_q <= '0;
				rank_q <= '0;
				if (is_rd) begin
					res_px_q <= item_q.pixels;
				end
			end
			S_DECIDE: begin
				rank_q <= rank_full;
				if (is_rd) begin
					res_px_q <= item_q.pixels;
				end else if (rank_full >= lim) begin
					status_q <= 1'b1;
				end else if (!present && item_q.pixels != 8'd0) begin
					if (total_q < lim) begin
						res_px_q <= item_q.pixels;
						del_q <= 1'b0;
						cp_q <= total_q;
					end else begin
						status_q <= 1'b1;
					end
				end
			end
			S_LREAD: begin
				if (is_rd) begin
					res_px_q <= item_q.keep_added ? (item_q.pixels ^ lst_rdata) :
						(item_q.pixels & ~lst_rdata);
				end else begin
					res_px_q <= e_new;
					del_q <= 1'b1;
					cp_q <= rank_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_data_q.pixels_out <= res_px_q;
			out_data_q.status <= status_q;
			out_data_q.entry_count <= cnt_wide[CFG_W-1:0];
		end
	end

	sxos_ram #(
		.WIDTH(16),
		.DEPTH(MAP_WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (bm_we),
		.waddr(word_q),
		.wdata(bm_wdata),
		.re   (bm_re),
		.raddr(bm_raddr),
		.rdata(bm_rdata)
	);

	sxos_ram #(
		.WIDTH(8),
		.DEPTH(LIST_DEPTH)
	) u_list (
		.clk  (clk),
		.we   (lst_we),
		.waddr(lst_waddr),
		.wdata(lst_wdata),
		.re   (lst_re),
		.raddr(lst_raddr),
		.rdata(lst_rdata)
	);

	`SXOS_NEVER(a_total_max, clk, arst_n, total_q > CNT_W'(LIST_DEPTH), "entry count beyond list depth")
	`SXOS_ASSERT(a_copy_state, clk, arst_n, cp_vld_s1 |-> (state_q == S_COPY || state_q == S_DRAIN), "copy beat outside shift")
	`SXOS_NEVER(a_list_rw, clk, arst_n, lst_we && lst_re && lst_waddr == lst_raddr, "list read and write hit one entry")
	`SXOS_ASSERT(a_out_from_fin, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_FIN), "result without finished item")

endmodule
